// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the program validator.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain property on every rising edge, skipped while in reset
`define BPV_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define BPV_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// ===== rtl/bpv_pkg.sv =====
// Package of the BPF program validator: limits, opcode codes and item types.
// Depends on nothing; used by bpv_check and bpf_program_validator top level.
package bpv_pkg;

	// Program limits
	localparam int FRAGMENT_INSNS   = 32;
	localparam int SCRATCH_WORDS    = 16;
	localparam int LENGTH_FRAGMENTS = 3;
	localparam int MAX_LENGTH       = LENGTH_FRAGMENTS * FRAGMENT_INSNS;

	// Instruction class that ends a program
	localparam logic [2:0] CLASS_RET = 3'h6;

	// Loads into the accumulator
	localparam logic [15:0] OP_LD_W_ABS = 16'h0020;
	localparam logic [15:0] OP_LD_H_ABS = 16'h0028;
	localparam logic [15:0] OP_LD_B_ABS = 16'h0030;
	localparam logic [15:0] OP_LD_W_LEN = 16'h0080;
	localparam logic [15:0] OP_LD_W_IND = 16'h0040;
	localparam logic [15:0] OP_LD_H_IND = 16'h0048;
	localparam logic [15:0] OP_LD_B_IND = 16'h0050;
	localparam logic [15:0] OP_LD_IMM   = 16'h0000;
	localparam logic [15:0] OP_LD_MEM   = 16'h0060;

	// Loads into the index register
	localparam logic [15:0] OP_LDX_LEN  = 16'h0081;
	localparam logic [15:0] OP_LDX_MSH  = 16'h00b1;
	localparam logic [15:0] OP_LDX_IMM  = 16'h0001;
	localparam logic [15:0] OP_LDX_MEM  = 16'h0061;

	// Scratch stores
	localparam logic [15:0] OP_ST       = 16'h0002;
	localparam logic [15:0] OP_STX      = 16'h0003;

	// Arithmetic and logic
	localparam logic [15:0] OP_ADD_K    = 16'h0004;
	localparam logic [15:0] OP_ADD_X    = 16'h000c;
	localparam logic [15:0] OP_SUB_K    = 16'h0014;
	localparam logic [15:0] OP_SUB_X    = 16'h001c;
	localparam logic [15:0] OP_MUL_K    = 16'h0024;
	localparam logic [15:0] OP_MUL_X    = 16'h002c;
	localparam logic [15:0] OP_DIV_K    = 16'h0034;
	localparam logic [15:0] OP_DIV_X    = 16'h003c;
	localparam logic [15:0] OP_OR_K     = 16'h0044;
	localparam logic [15:0] OP_OR_X     = 16'h004c;
	localparam logic [15:0] OP_AND_K    = 16'h0054;
	localparam logic [15:0] OP_AND_X    = 16'h005c;
	localparam logic [15:0] OP_LSH_K    = 16'h0064;
	localparam logic [15:0] OP_LSH_X    = 16'h006c;
	localparam logic [15:0] OP_RSH_K    = 16'h0074;
	localparam logic [15:0] OP_RSH_X    = 16'h007c;
	localparam logic [15:0] OP_NEG      = 16'h0084;

	// Jumps
	localparam logic [15:0] OP_JA       = 16'h0005;
	localparam logic [15:0] OP_JEQ_K    = 16'h0015;
	localparam logic [15:0] OP_JEQ_X    = 16'h001d;
	localparam logic [15:0] OP_JGT_K    = 16'h0025;
	localparam logic [15:0] OP_JGT_X    = 16'h002d;
	localparam logic [15:0] OP_JGE_K    = 16'h0035;
	localparam logic [15:0] OP_JGE_X    = 16'h003d;
	localparam logic [15:0] OP_JSET_K   = 16'h0045;
	localparam logic [15:0] OP_JSET_X   = 16'h004d;

	// Returns and register moves
	localparam logic [15:0] OP_RET_K    = 16'h0006;
	localparam logic [15:0] OP_RET_A    = 16'h0016;
	localparam logic [15:0] OP_TAX      = 16'h0007;
	localparam logic [15:0] OP_TXA      = 16'h0087;

	// One instruction as it arrives
	typedef struct packed {
		logic [31:0] constant_k;
		logic [7:0]  jump_false;
		logic [7:0]  jump_true;
		logic [15:0] opcode;
	} insn_t;

	// Verdict on one instruction
	typedef struct packed {
		logic insn_ok;
		logic is_last;
		logic program_ok;
	} chk_res_t;

endpackage

// ===== rtl/bpv_check.sv =====
// Combinational checks of one BPF instruction against the program state.
// Depends on bpv_pkg for opcode codes, limits and item types.
module bpv_check (
	input  bpv_pkg::insn_t    insn,
	input  logic [7:0]        position,
	input  logic [7:0]        program_length,
	input  logic              error_seen,
	output bpv_pkg::chk_res_t res
);
	import bpv_pkg::*;

	logic [9:0] pos_w;
	logic [9:0] len_w;
	logic [9:0] jt_target;
	logic [9:0] jf_target;
	logic [9:0] ja_target;
	logic [8:0] next_pos;
	logic       ja_ok;
	logic       jc_ok;
	logic       len_ok;
	logic       ok;
	logic       last;

	// Jump targets, wide enough that no sum wraps
	assign pos_w     = {2'b00, position};
	assign len_w     = {2'b00, program_length};
	assign jt_target = pos_w + {2'b00, insn.jump_true} + 10'd1;
	assign jf_target = pos_w + {2'b00, insn.jump_false} + 10'd1;
	assign ja_target = pos_w + {2'b00, insn.constant_k[7:0]} + 10'd1;
	assign ja_ok     = (insn.constant_k[31:8] == 24'd0) && (ja_target < len_w);
	assign jc_ok     = (jt_target < len_w) && (jf_target < len_w);

	// Whitelist the opcode and test its operands
	always_comb begin
		case (insn.opcode) inside
			OP_ADD_K, OP_ADD_X, OP_SUB_K, OP_SUB_X, OP_MUL_K, OP_MUL_X,
			OP_DIV_X, OP_AND_K, OP_AND_X, OP_OR_K, OP_OR_X, OP_LSH_K,
			OP_LSH_X, OP_RSH_K, OP_RSH_X, OP_NEG,
			OP_LD_W_ABS, OP_LD_H_ABS, OP_LD_B_ABS, OP_LD_W_LEN,
			OP_LD_W_IND, OP_LD_H_IND, OP_LD_B_IND, OP_LD_IMM,
			OP_LDX_LEN, OP_LDX_MSH, OP_LDX_IMM,
			OP_TAX, OP_TXA, OP_RET_K, OP_RET_A: begin
				ok = 1'b1;
			end
			OP_DIV_K: begin
				ok = insn.constant_k != 32'd0;
			end
			OP_LD_MEM, OP_LDX_MEM, OP_ST, OP_STX: begin
				ok = insn.constant_k < 32'(SCRATCH_WORDS);
			end
			OP_JA: begin
				ok = ja_ok;
			end
			OP_JEQ_K, OP_JEQ_X, OP_JGE_K, OP_JGE_X,
			OP_JGT_K, OP_JGT_X, OP_JSET_K, OP_JSET_X: begin
				ok = jc_ok;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Close the program at its length; a zero length closes every item
	assign next_pos = {1'b0, position} + 9'd1;
	assign last     = (program_length == 8'd0) || (next_pos >= {1'b0, program_length});
	assign len_ok   = (program_length != 8'd0) && (len_w <= 10'(MAX_LENGTH));

	assign res.insn_ok    = ok;
	assign res.is_last    = last;
	assign res.program_ok = last && len_ok && ok && !error_seen &&
	                        (insn.opcode[2:0] == CLASS_RET);

endmodule

// ===== rtl/bpf_program_validator.sv =====
// Input register, then result register; one item per cycle while m_tready stays high.
// The input register feeds the opcode and target checks, whose verdict lands in the
// result register; position and the sticky error update as an item leaves the input stage.
// Reset (arst_n low, asynchronous) clears the valid flags of both stages, position,
// the error flag and program_length to zero.
// Top level of the BPF program validator: input stage, program state, result stage.
// Depends on bpv_pkg and bpv_check; assertions use assert_macros.svh.
`include "assert_macros.svh"

module bpf_program_validator (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: program_length
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input item
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // opcode[15:0], jump_true[23:16], jump_false[31:24],
	                               // constant_k[63:32]
	// result item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // insn_ok[0], program_ok[1], zero [7:2]
	output logic        m_tlast    // is_last
);
	import bpv_pkg::*;

	logic          valid_s1;
	insn_t         insn_s1;
	logic          valid_s2;
	chk_res_t      res_s2;
	logic [7:0]    program_length_q;
	logic [7:0]    position_q;
	logic          error_q;
	chk_res_t      res;
	logic          advance;

	// Move stage one on when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Hold the configured length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= 8'd0;
		end else if (cfg_we) begin
			program_length_q <= cfg_wdata;
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			insn_s1 <= insn_t'(s_tdata);
		end
	end

	bpv_check u_check (
		.insn           (insn_s1),
		.position       (position_q),
		.program_length (program_length_q),
		.error_seen     (error_q),
		.res            (res)
	);

	// Advance position and the sticky error; wrap both at the end of a program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 8'd0;
			error_q    <= 1'b0;
		end else if (advance) begin
			if (res.is_last) begin
				position_q <= 8'd0;
				error_q    <= 1'b0;
			end else begin
				position_q <= position_q + 8'd1;
				error_q    <= error_q || !res.insn_ok;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.program_ok, res_s2.insn_ok};
	assign m_tlast  = res_s2.is_last;

	// A valid program verdict only closes a program of passing instructions
	`BPV_ASSERT_IMP(a_prog_ok_last, clk, arst_n, m_tvalid && m_tdata[1],
		m_tlast && m_tdata[0], "program_ok without is_last and insn_ok")
	// Closing a program clears the program state
	`BPV_ASSERT(a_wrap, clk, arst_n, advance && res.is_last |=> position_q == 8'd0 && !error_q,
		"state not cleared after the last instruction")
	// A remembered error belongs to a program already under way
	`BPV_ASSERT_IMP(a_err_pos, clk, arst_n, error_q, position_q != 8'd0,
		"error flag set at program start")
	// An empty result register never blocks the input
	`BPV_ASSERT_IMP(a_ready, clk, arst_n, !m_tvalid, s_tready,
		"input stalled while the result register is empty")

endmodule
